// File: hdl/mnh_pkg.sv
`default_nettype none
package mnh_pkg;

  localparam int HISTORY_DEPTH = 8;
  localparam int CHANNELS      = 16;
  localparam int CONTROLLERS   = 128;
  localparam int MAX_RESULTS   = 8;
  localparam int QUEUE_DEPTH   = 2;

  localparam int NRES     = (HISTORY_DEPTH < MAX_RESULTS) ? HISTORY_DEPTH : MAX_RESULTS;
  localparam int HIDX_W   = $clog2(HISTORY_DEPTH);
  localparam int CC_DEPTH = CHANNELS * CONTROLLERS;
  localparam int CC_AW    = (CC_DEPTH > 1) ? $clog2(CC_DEPTH) : 1;
  localparam int QPTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [19:0] AGE_MAX       = 20'hFFFFF;
  localparam logic [19:0] LIFETIME_INIT = 20'd2000;

  localparam logic [2:0] MODE_NOTE_ON  = 3'd0;
  localparam logic [2:0] MODE_CC       = 3'd1;
  localparam logic [2:0] MODE_TICK     = 3'd2;
  localparam logic [2:0] MODE_READ_HIS = 3'd3;
  localparam logic [2:0] MODE_READ_CC  = 3'd4;

  typedef enum logic [2:0] {
    OP_NOTE,
    OP_CC,
    OP_TICK,
    OP_RD_HIS,
    OP_RD_CC
  } op_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [3:0]  channel;
    logic [6:0]  number;
    logic [6:0]  value;
    logic [15:0] elapsed_ms;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  slot;
    logic        entry_active;
    logic [6:0]  entry_note;
    logic [6:0]  entry_velocity;
    logic [3:0]  entry_channel;
    logic [19:0] entry_age;
    logic [6:0]  primary_note;
    logic [6:0]  primary_velocity;
    logic [6:0]  cc_value;
    logic        last;
  } out_res_t;

  typedef struct packed {
    op_t         op;
    logic [3:0]  channel;
    logic [6:0]  number;
    logic [6:0]  value;
    logic [15:0] elapsed_ms;
  } cmd_t;

  typedef struct packed {
    logic        active;
    logic [6:0]  note;
    logic [6:0]  velocity;
    logic [3:0]  channel;
    logic [19:0] age;
  } slot_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

// File: hdl/mnh_front.sv
`default_nettype none
module mnh_front (
  input  wire logic             start,
  input  wire mnh_pkg::in_req_t in_data,
  input  wire logic             q_full,
  input  wire logic             clearing,
  output logic                  busy,
  output logic                  push,
  output mnh_pkg::cmd_t         cmd
);

  logic useful;

  assign busy = q_full | clearing;

  always_comb begin
    cmd.channel    = in_data.channel;
    cmd.number     = in_data.number;
    cmd.value      = in_data.value;
    cmd.elapsed_ms = in_data.elapsed_ms;
    cmd.op         = mnh_pkg::OP_NOTE;
    useful         = 1'b0;
    unique case (in_data.mode)
      mnh_pkg::MODE_NOTE_ON: begin
        cmd.op = mnh_pkg::OP_NOTE;
        useful = (in_data.value != 7'd0);
      end
      mnh_pkg::MODE_CC: begin
        cmd.op = mnh_pkg::OP_CC;
        useful = 1'b1;
      end
      mnh_pkg::MODE_TICK: begin
        cmd.op = mnh_pkg::OP_TICK;
        useful = (in_data.elapsed_ms != 16'd0);
      end
      mnh_pkg::MODE_READ_HIS: begin
        cmd.op = mnh_pkg::OP_RD_HIS;
        useful = 1'b1;
      end
      mnh_pkg::MODE_READ_CC: begin
        cmd.op = mnh_pkg::OP_RD_CC;
        useful = 1'b1;
      end
      default: begin
        useful = 1'b0;
      end
    endcase
  end

  // dropped requests never reach the queue
  assign push = start & ~busy & useful;

endmodule
`default_nettype wire

// File: hdl/mnh_queue.sv
`default_nettype none
module mnh_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire mnh_pkg::cmd_t cmd_in,
  input  wire logic          pop,
  output mnh_pkg::cmd_t      cmd_out,
  output mnh_pkg::q_stat_t   stat
);

  mnh_pkg::cmd_t                 q_r [mnh_pkg::QUEUE_DEPTH];
  logic [mnh_pkg::QPTR_W-1:0]    wptr_r;
  logic [mnh_pkg::QPTR_W-1:0]    rptr_r;
  logic [mnh_pkg::QCNT_W-1:0]    cnt_r;
  logic                          do_push;
  logic                          do_pop;

  assign stat.full  = (cnt_r == mnh_pkg::QCNT_W'(mnh_pkg::QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push & ~stat.full;
  assign do_pop     = pop & ~stat.empty;
  assign cmd_out    = q_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        if (wptr_r == mnh_pkg::QPTR_W'(mnh_pkg::QUEUE_DEPTH - 1)) wptr_r <= '0;
        else wptr_r <= wptr_r + 1'b1;
      end
      if (do_pop) begin
        if (rptr_r == mnh_pkg::QPTR_W'(mnh_pkg::QUEUE_DEPTH - 1)) rptr_r <= '0;
        else rptr_r <= rptr_r + 1'b1;
      end
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: hdl/mnh_back.sv
`default_nettype none
module mnh_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [19:0]      cfg_wdata,
  input  wire mnh_pkg::cmd_t    head,
  input  wire logic             q_empty,
  output logic                  pop,
  output logic                  clearing,
  output logic                  out_valid,
  output mnh_pkg::out_res_t     out_data
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_EMIT,
    S_CC
  } state_t;

  state_t                       state_r;
  logic [19:0]                  lifetime_r;
  mnh_pkg::slot_t               hist_r [mnh_pkg::HISTORY_DEPTH];
  logic [mnh_pkg::HIDX_W-1:0]   idx_r;
  logic [mnh_pkg::CC_AW-1:0]    clr_r;
  logic                         found_r;
  logic [6:0]                   pnote_r;
  logic [6:0]                   pvel_r;
  logic                         cc_ok_r;
  logic                         out_valid_r;
  mnh_pkg::out_res_t            out_data_r;

  logic [6:0]                   mem [mnh_pkg::CC_DEPTH];
  logic [6:0]                   rdata_r;
  logic                         mem_we;
  logic [mnh_pkg::CC_AW-1:0]    mem_waddr;
  logic [6:0]                   mem_wdata;
  logic [mnh_pkg::CC_AW-1:0]    head_addr;
  logic                         head_ok;
  mnh_pkg::slot_t               hslot;

  assign clearing  = (state_r == S_CLEAR);
  assign pop       = (state_r == S_IDLE) && !q_empty;
  assign head_ok   = (32'(head.channel) < mnh_pkg::CHANNELS) &&
                     (32'(head.number) < mnh_pkg::CONTROLLERS);
  assign head_addr = mnh_pkg::CC_AW'(32'(head.channel) * mnh_pkg::CONTROLLERS +
                                     32'(head.number));
  assign hslot     = hist_r[idx_r];

  assign mem_we    = clearing || (pop && head.op == mnh_pkg::OP_CC && head_ok);
  assign mem_waddr = clearing ? clr_r : head_addr;
  assign mem_wdata = clearing ? 7'd0 : head.value;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[head_addr];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    logic [20:0] sum;
    logic [19:0] sat;
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      lifetime_r  <= mnh_pkg::LIFETIME_INIT;
      idx_r       <= '0;
      clr_r       <= '0;
      found_r     <= 1'b0;
      pnote_r     <= '0;
      pvel_r      <= '0;
      cc_ok_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < mnh_pkg::HISTORY_DEPTH; i++) begin
        hist_r[i] <= '0;
      end
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) lifetime_r <= cfg_wdata;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == mnh_pkg::CC_AW'(mnh_pkg::CC_DEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (pop) begin
            unique case (head.op)
              mnh_pkg::OP_NOTE: begin
                for (int i = mnh_pkg::HISTORY_DEPTH - 1; i > 0; i--) begin
                  hist_r[i] <= hist_r[i-1];
                end
                hist_r[0].active   <= 1'b1;
                hist_r[0].note     <= head.number;
                hist_r[0].velocity <= head.value;
                hist_r[0].channel  <= head.channel;
                hist_r[0].age      <= '0;
              end
              mnh_pkg::OP_TICK: begin
                for (int i = 0; i < mnh_pkg::HISTORY_DEPTH; i++) begin
                  sum = {1'b0, hist_r[i].age} + 21'(head.elapsed_ms);
                  sat = sum[20] ? mnh_pkg::AGE_MAX : sum[19:0];
                  if (hist_r[i].active) begin
                    if (sat > lifetime_r) hist_r[i] <= '0;
                    else hist_r[i].age <= sat;
                  end
                end
              end
              mnh_pkg::OP_RD_HIS: begin
                idx_r   <= '0;
                found_r <= 1'b0;
                pnote_r <= '0;
                pvel_r  <= '0;
                state_r <= S_SCAN;
              end
              mnh_pkg::OP_RD_CC: begin
                cc_ok_r <= head_ok;
                state_r <= S_CC;
              end
              default: begin
                // control change: table write done by the memory port
              end
            endcase
          end
        end
        S_SCAN: begin
          if (!found_r && hslot.active) begin
            found_r <= 1'b1;
            pnote_r <= hslot.note;
            pvel_r  <= hslot.velocity;
          end
          if (idx_r == mnh_pkg::HIDX_W'(mnh_pkg::HISTORY_DEPTH - 1)) begin
            idx_r   <= '0;
            state_r <= S_EMIT;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_EMIT: begin
          out_valid_r                 <= 1'b1;
          out_data_r.slot             <= 3'(idx_r);
          out_data_r.entry_active     <= hslot.active;
          out_data_r.entry_note       <= hslot.active ? hslot.note : 7'd0;
          out_data_r.entry_velocity   <= hslot.active ? hslot.velocity : 7'd0;
          out_data_r.entry_channel    <= hslot.active ? hslot.channel : 4'd0;
          out_data_r.entry_age        <= hslot.active ? hslot.age : 20'd0;
          out_data_r.primary_note     <= pnote_r;
          out_data_r.primary_velocity <= pvel_r;
          out_data_r.cc_value         <= 7'd0;
          if (idx_r == mnh_pkg::HIDX_W'(mnh_pkg::NRES - 1)) begin
            out_data_r.last <= 1'b1;
            idx_r           <= '0;
            state_r         <= S_IDLE;
          end else begin
            out_data_r.last <= 1'b0;
            idx_r           <= idx_r + 1'b1;
          end
        end
        S_CC: begin
          out_valid_r                 <= 1'b1;
          out_data_r.slot             <= 3'd0;
          out_data_r.entry_active     <= 1'b0;
          out_data_r.entry_note       <= 7'd0;
          out_data_r.entry_velocity   <= 7'd0;
          out_data_r.entry_channel    <= 4'd0;
          out_data_r.entry_age        <= 20'd0;
          out_data_r.primary_note     <= 7'd0;
          out_data_r.primary_velocity <= 7'd0;
          out_data_r.cc_value         <= cc_ok_r ? rdata_r : 7'd0;
          out_data_r.last             <= 1'b1;
          state_r                     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hdl/midi_note_history_and_cc_table.sv
// Note-on, control change and tick: each is applied by the back end when it takes it from the queue.
// History read: the back end scans every history slot, then emits min(HISTORY_DEPTH, 8) results,
//   one result per emit cycle.
// Cc read: one result, taken from a registered read of the controller table.
// A two-entry queue lets requests be taken while the back end works; busy rises when it is full.
// Reset: history cleared at once; a pass over all 2048 entries clears the controller table with busy high.
`default_nettype none
module midi_note_history_and_cc_table (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire mnh_pkg::in_req_t in_data,
  input  wire logic             cfg_we,
  input  wire logic [19:0]      cfg_wdata,
  output logic                  out_valid,
  output mnh_pkg::out_res_t     out_data
);

  logic             push;
  logic             pop;
  logic             clearing;
  mnh_pkg::cmd_t    cmd_in;
  mnh_pkg::cmd_t    cmd_head;
  mnh_pkg::q_stat_t q_stat;

  mnh_front u_front (
    .start    (start),
    .in_data  (in_data),
    .q_full   (q_stat.full),
    .clearing (clearing),
    .busy     (busy),
    .push     (push),
    .cmd      (cmd_in)
  );

  mnh_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .cmd_in  (cmd_in),
    .pop     (pop),
    .cmd_out (cmd_head),
    .stat    (q_stat)
  );

  mnh_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .head      (cmd_head),
    .q_empty   (q_stat.empty),
    .pop       (pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// File: hdl/mnh_checker.sv
`default_nettype none
module mnh_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire mnh_pkg::out_res_t out_data
);

  // a history run is emitted without gaps, slot by slot
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |=> out_valid && (out_data.slot == $past(out_data.slot) + 3'd1))
    else $error("history run broken");

  a_inactive_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.entry_active |-> out_data.entry_note == 7'd0 &&
      out_data.entry_velocity == 7'd0 && out_data.entry_channel == 4'd0 &&
      out_data.entry_age == 20'd0)
    else $error("inactive slot shows data");

  a_cc_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.cc_value != 7'd0 |-> out_data.last && out_data.slot == 3'd0 &&
      !out_data.entry_active && out_data.primary_velocity == 7'd0)
    else $error("cc result malformed");

  // a live note always carries a nonzero velocity
  a_primary: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.primary_velocity == 7'd0 |-> out_data.primary_note == 7'd0)
    else $error("primary note without velocity");

endmodule

bind midi_note_history_and_cc_table mnh_checker u_mnh_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_data  (out_data)
);
`default_nettype wire
